/* hw/rtl/isc_pkg.sv */
// Shared constants, types and helper functions of the iSLIP crossbar scheduler.
package isc_pkg;

    localparam int PORTS          = 8;
    localparam int MAX_ITERATIONS = 8;
    localparam int RESULT_SLOTS   = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam int PW      = $clog2(PORTS);
    localparam int NW      = $clog2(PORTS + 1);
    localparam int IW      = $clog2(MAX_ITERATIONS + 1);
    localparam int CW      = $clog2(RESULT_SLOTS + 1);
    localparam int QW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW     = $clog2(QUEUE_DEPTH + 1);

    localparam int SRC_W   = 3;
    localparam int MASK_W  = 8;
    localparam int MATCH_W = 3;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PORTS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0]     ACTIVE_PORTS_RESET    = CFG_W'(8);
    localparam logic [CFG_W-1:0]     ITERATION_COUNT_RESET = CFG_W'(3);

    typedef logic [PW-1:0]    t_port;
    typedef logic [PORTS-1:0] t_row;
    typedef logic [NW-1:0]    t_nports;
    typedef logic [IW-1:0]    t_iters;

    typedef struct packed {
        logic  load;
        t_port src;
        t_row  row;
        logic  eor;
    } t_cmd;

    typedef struct packed {
        logic               match_valid;
        logic [MATCH_W-1:0] match_input;
        logic [MATCH_W-1:0] match_output;
        logic               last_match;
    } t_result;

    function automatic t_nports sat_ports(input logic [CFG_W-1:0] v);
        t_nports r;
        if (v == '0) begin
            r = t_nports'(1);
        end else if (int'(v) > PORTS) begin
            r = t_nports'(PORTS);
        end else begin
            r = t_nports'(v);
        end
        return r;
    endfunction

    function automatic t_iters sat_iters(input logic [CFG_W-1:0] v);
        t_iters r;
        if (v == '0) begin
            r = t_iters'(1);
        end else if (int'(v) > MAX_ITERATIONS) begin
            r = t_iters'(MAX_ITERATIONS);
        end else begin
            r = t_iters'(v);
        end
        return r;
    endfunction

    function automatic t_row live_mask(input t_nports n);
        t_row m;
        for (int j = 0; j < PORTS; j++) begin
            m[j] = (j < int'(n));
        end
        return m;
    endfunction

    function automatic t_row widen_mask(input logic [MASK_W-1:0] mask);
        t_row r;
        r = '0;
        for (int j = 0; j < PORTS && j < MASK_W; j++) begin
            r[j] = mask[j];
        end
        return r;
    endfunction

    // Round-robin pick: the first candidate at or above start, else the lowest one.
    function automatic t_row rr_onehot(input t_row c, input t_port start);
        t_row hi;
        t_row sel;
        for (int j = 0; j < PORTS; j++) begin
            hi[j] = (j >= int'(start));
        end
        sel = ((c & hi) != '0) ? (c & hi) : c;
        return sel & (~sel + t_row'(1));
    endfunction

    function automatic t_port onehot_index(input t_row v);
        t_port idx;
        idx = '0;
        for (int j = 0; j < PORTS; j++) begin
            if (v[j]) begin
                idx = idx | t_port'(j);
            end
        end
        return idx;
    endfunction

    function automatic t_port ptr_start(input t_port ptr, input t_nports n);
        return (int'(ptr) < int'(n)) ? ptr : '0;
    endfunction

    function automatic t_port ptr_next(input t_port idx, input t_nports n);
        t_nports t;
        t = t_nports'(idx) + t_nports'(1);
        return (t == n) ? '0 : t_port'(t);
    endfunction

endpackage

/* hw/rtl/isc_front.sv */
// Front end: accepts request items, classifies them and queues them for the engine.
module isc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [2:0]     i_source_port,
    input  logic [7:0]     i_request_mask,
    input  logic           i_end_of_round,
    input  isc_pkg::t_nports i_port_count,
    output logic           o_cmd_valid,
    output isc_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_pop
);
    import isc_pkg::*;

    t_cmd            r_queue [QUEUE_DEPTH];
    logic [QW-1:0]   r_wr_ptr;
    logic [QW-1:0]   r_rd_ptr;
    logic [QCW-1:0]  r_count;
    t_cmd            n_cmd;
    logic            push;
    logic            pop;

    always_comb begin
        n_cmd.load = (int'(i_source_port) < int'(i_port_count));
        n_cmd.src  = t_port'(i_source_port);
        n_cmd.row  = widen_mask(i_request_mask) & live_mask(i_port_count);
        n_cmd.eor  = i_end_of_round;
    end

    assign o_ready     = (int'(r_count) < QUEUE_DEPTH);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_queue[r_wr_ptr] <= n_cmd;
                r_wr_ptr <= (int'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + QW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + QW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

endmodule

/* hw/rtl/isc_engine.sv */
// Back end: holds the request matrix and pointers, runs the iSLIP iterations and emits matches.
module isc_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  isc_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    input  isc_pkg::t_nports i_port_count,
    input  isc_pkg::t_iters  i_iter_count,
    output logic             o_out_valid,
    output isc_pkg::t_result o_result,
    input  logic             i_out_ready
);
    import isc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GRANT,
        S_ACCEPT,
        S_EMIT,
        S_FINISH
    } t_state;

    t_state          r_state;
    t_iters          r_iter;
    t_row            r_req   [PORTS];
    t_port           r_gptr  [PORTS];
    t_port           r_aptr  [PORTS];
    t_row            r_grant [PORTS];
    t_row            r_imatch;
    t_row            r_omatch;
    t_row            r_acc_valid;
    t_port           r_acc_out [PORTS];
    logic            r_hold_valid;
    t_port           r_hold_in;
    t_port           r_hold_out;
    logic [CW-1:0]   r_cnt;
    logic            r_out_valid;
    t_result         r_out;

    t_row            live;
    t_row            gnt_col [PORTS];
    t_row            n_grant [PORTS];
    t_row            acc_oh  [PORTS];
    t_row            acc_valid;
    t_port           acc_out [PORTS];
    t_row            acc_omask;
    t_row            e_oh;
    t_port           e_idx;
    logic            out_free;
    logic            out_load;

    assign live     = live_mask(i_port_count);
    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = out_free && (((r_state == S_EMIT) && (r_acc_valid != '0)
                                    && (int'(r_cnt) != RESULT_SLOTS) && r_hold_valid)
                                   || (r_state == S_FINISH));
    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        t_row cand;
        for (int o = 0; o < PORTS; o++) begin
            for (int p = 0; p < PORTS; p++) begin
                cand[p] = r_req[p][o] && !r_imatch[p] && live[p];
            end
            if (!live[o] || r_omatch[o]) begin
                cand = '0;
            end
            gnt_col[o] = rr_onehot(cand, ptr_start(r_gptr[o], i_port_count));
        end
        for (int p = 0; p < PORTS; p++) begin
            for (int o = 0; o < PORTS; o++) begin
                n_grant[p][o] = gnt_col[o][p];
            end
        end
    end

    always_comb begin
        t_row cand;
        acc_omask = '0;
        for (int i = 0; i < PORTS; i++) begin
            cand = r_grant[i] & ~r_omatch & live;
            if (!live[i] || r_imatch[i]) begin
                cand = '0;
            end
            acc_oh[i]    = rr_onehot(cand, ptr_start(r_aptr[i], i_port_count));
            acc_valid[i] = (acc_oh[i] != '0);
            acc_out[i]   = onehot_index(acc_oh[i]);
            acc_omask    = acc_omask | acc_oh[i];
        end
    end

    assign e_oh  = r_acc_valid & (~r_acc_valid + t_row'(1));
    assign e_idx = onehot_index(e_oh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_iter       <= '0;
            r_imatch     <= '0;
            r_omatch     <= '0;
            r_acc_valid  <= '0;
            r_hold_valid <= 1'b0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < PORTS; k++) begin
                r_req[k]  <= '0;
                r_gptr[k] <= '0;
                r_aptr[k] <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        for (int k = 0; k < PORTS; k++) begin
                            if (i_cmd.load && i_cmd.src == t_port'(k)) begin
                                r_req[k] <= r_req[k] | i_cmd.row;
                            end
                        end
                        if (i_cmd.eor) begin
                            r_iter  <= '0;
                            r_state <= S_GRANT;
                        end
                    end
                end
                S_GRANT: begin
                    for (int k = 0; k < PORTS; k++) begin
                        r_grant[k] <= n_grant[k];
                    end
                    r_state <= S_ACCEPT;
                end
                S_ACCEPT: begin
                    r_acc_valid <= acc_valid;
                    for (int k = 0; k < PORTS; k++) begin
                        r_acc_out[k] <= acc_out[k];
                    end
                    r_imatch <= r_imatch | acc_valid;
                    r_omatch <= r_omatch | acc_omask;
                    if (r_iter == '0) begin
                        for (int i = 0; i < PORTS; i++) begin
                            if (acc_valid[i]) begin
                                r_aptr[i] <= ptr_next(acc_out[i], i_port_count);
                            end
                            for (int o = 0; o < PORTS; o++) begin
                                if (acc_oh[i][o]) begin
                                    r_gptr[o] <= ptr_next(t_port'(i), i_port_count);
                                end
                            end
                        end
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_acc_valid != '0) begin
                        if (int'(r_cnt) == RESULT_SLOTS) begin
                            r_acc_valid <= r_acc_valid & ~e_oh;
                        end else if (!r_hold_valid || out_free) begin
                            if (r_hold_valid) begin
                                r_out.match_valid  <= 1'b1;
                                r_out.match_input  <= MATCH_W'(r_hold_in);
                                r_out.match_output <= MATCH_W'(r_hold_out);
                                r_out.last_match   <= 1'b0;
                            end
                            r_hold_valid <= 1'b1;
                            r_hold_in    <= e_idx;
                            r_hold_out   <= r_acc_out[e_idx];
                            r_cnt        <= r_cnt + CW'(1);
                            r_acc_valid  <= r_acc_valid & ~e_oh;
                        end
                    end else if (t_iters'(r_iter + t_iters'(1)) == i_iter_count) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_iter  <= r_iter + t_iters'(1);
                        r_state <= S_GRANT;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out.match_valid  <= r_hold_valid;
                        r_out.match_input  <= r_hold_valid ? MATCH_W'(r_hold_in) : '0;
                        r_out.match_output <= r_hold_valid ? MATCH_W'(r_hold_out) : '0;
                        r_out.last_match   <= 1'b1;
                        r_hold_valid       <= 1'b0;
                        r_cnt              <= '0;
                        r_imatch           <= '0;
                        r_omatch           <= '0;
                        for (int k = 0; k < PORTS; k++) begin
                            r_req[k] <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_match_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_imatch) == $countones(r_omatch))
        else $error("Matched input and output counts differ.");

    a_pending_matched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_valid & ~r_imatch) == '0)
        else $error("A pending match belongs to an unmatched input.");

    a_hold_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid == (r_cnt != '0))
        else $error("Held result and result count disagree.");

    a_finish_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && out_free) |=> (r_out_valid && r_out.last_match))
        else $error("Round closed without a final result.");
`endif

endmodule

/* hw/rtl/islip_crossbar_scheduler_core.sv */
// Top level of the iSLIP crossbar scheduler: configuration registers, front end and engine.
//
// Channel   Direction  Handshake                  Payload
// request   in         i_valid / o_ready          source_port, request_mask, end_of_round
// match     out        o_valid / i_ready          match_valid, match_input, match_output,
//                                                 last_match
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// The engine takes row items while idle; a two-item queue lets the front end keep accepting.
// A round runs grant, accept and emit steps for each iteration, emitting matches one at a
// time, then a closing step, all in the engine sequencer.
// Synchronous active-low reset clears requests and pointers and loads the default
// configuration. A stalled match output holds the engine; the queue then fills and
// the request channel stalls.
module islip_crossbar_scheduler_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [isc_pkg::SRC_W-1:0]         i_source_port,
    input  logic [isc_pkg::MASK_W-1:0]        i_request_mask,
    input  logic                              i_end_of_round,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_match_valid,
    output logic [isc_pkg::MATCH_W-1:0]       o_match_input,
    output logic [isc_pkg::MATCH_W-1:0]       o_match_output,
    output logic                              o_last_match,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [isc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [isc_pkg::CFG_W-1:0]         i_cfg_data
);
    import isc_pkg::*;

    logic [CFG_W-1:0] r_active_ports;
    logic [CFG_W-1:0] r_iteration_count;
    t_nports          port_count;
    t_iters           iter_count;
    logic             cmd_valid;
    t_cmd             cmd;
    logic             cmd_pop;
    t_result          result;

    assign o_cfg_ready = 1'b1;
    assign port_count  = sat_ports(r_active_ports);
    assign iter_count  = sat_iters(r_iteration_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_ports    <= ACTIVE_PORTS_RESET;
            r_iteration_count <= ITERATION_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_ACTIVE_PORTS) begin
                r_active_ports <= i_cfg_data;
            end else if (i_cfg_index == CFG_ITERATION_COUNT) begin
                r_iteration_count <= i_cfg_data;
            end
        end
    end

    isc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_source_port  (i_source_port),
        .i_request_mask (i_request_mask),
        .i_end_of_round (i_end_of_round),
        .i_port_count   (port_count),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    isc_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .i_port_count (port_count),
        .i_iter_count (iter_count),
        .o_out_valid  (o_valid),
        .o_result     (result),
        .i_out_ready  (i_ready)
    );

    assign o_match_valid  = result.match_valid;
    assign o_match_input  = result.match_input;
    assign o_match_output = result.match_output;
    assign o_last_match   = result.last_match;

endmodule
